>>> rtl/icb_pkg.sv
// ----------------------------------------------------------------------------
// icb_pkg: shared types and constants of the clamped-border convolution block
// Kernel geometry, field widths, register indexes and the request records
// that pass between the front end, the job queue and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package icb_pkg;

    localparam int KSIZE     = 3;
    localparam int MAX_WIDTH = 1024;
    localparam int KLO       = KSIZE / 2;
    localparam int KHI       = KSIZE - 1 - KLO;
    localparam int NTAP      = KSIZE * KSIZE;

    localparam int COEFS_PER_WORD = 5;
    localparam int NWORD          = 5;
    localparam int COEF_W         = 12;
    localparam int CFG_W          = 60;
    localparam int CFG_IDX_W      = 3;

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int SLOT_W = (KSIZE > 1) ? $clog2(KSIZE) : 1;

    localparam int PIX_W  = 8;
    localparam int COL_W  = 10;
    localparam int ROW_W  = 12;
    localparam int WID_W  = 11;
    localparam int SUM_W  = 16;
    localparam int PROD_W = PIX_W + 1 + COEF_W;
    localparam int T_W    = SUM_W + 10;

    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 40;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QLVL_W = QPTR_W + 1;

    // Below this frame width a queued request could see its taps overwritten
    // by the pixels that follow it, so the front end waits for an empty queue.
    localparam int SAFE_W = 16;

    localparam int RECIP_SH = 16;
    localparam int RECIP    = ((1 << RECIP_SH) + KSIZE - 1) / KSIZE;
    localparam int RECIP_W  = RECIP_SH + 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF0  = 3'd0,
        REG_COEF1  = 3'd1,
        REG_COEF2  = 3'd2,
        REG_COEF3  = 3'd3,
        REG_COEF4  = 3'd4,
        REG_WIDTH  = 3'd5,
        REG_HEIGHT = 3'd6
    } reg_idx_t;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_FLUSH = 1'b1
    } req_t;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } job_t;

    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [PIX_W-1:0]  data;
    } wr_t;

    typedef struct packed {
        logic [NWORD-1:0][CFG_W-1:0] coef;
        logic [WID_W-1:0]            width;
        logic [ROW_W-1:0]            height;
    } cfg_t;

    // Row number modulo KSIZE by reciprocal multiplication and one correction.
    function automatic logic [SLOT_W-1:0] slot_of(input logic [ROW_W-1:0] x);
        logic [ROW_W+RECIP_W-1:0] prod;
        logic [ROW_W-1:0]         q;
        logic [ROW_W-1:0]         r;
        prod = (ROW_W+RECIP_W)'(x) * (ROW_W+RECIP_W)'(RECIP);
        q    = prod[ROW_W+RECIP_SH-1:RECIP_SH];
        r    = x - ROW_W'(q * ROW_W'(KSIZE));
        if (r >= ROW_W'(KSIZE)) begin
            r = r - ROW_W'(KSIZE);
        end
        return SLOT_W'(r);
    endfunction

endpackage

`default_nettype wire

>>> rtl/image_convolution_clamped_border_top.sv
// A request passes the queue, the RAM read register and the tap stages.
// Throughput: one request per cycle when the frame width is 16 or more and the
// queue has room; narrower frames make the intake wait until the queue drains.
// All taps are read in the same cycle from per-column copies of the line memory.
// Reset (aresetn low, synchronous) clears counters, queue and valid flags and
// restores the default registers; the line memory keeps its contents.
// ----------------------------------------------------------------------------
// image_convolution_clamped_border_top: replicate-border 2D convolution
// Raster pixel stream in, one saturated convolution result per pixel out,
// tagged with its column, row and end of frame.
// ----------------------------------------------------------------------------
`default_nettype none

module image_convolution_clamped_border_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          cfg_wr_en,
    input  wire logic [icb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [icb_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [icb_pkg::S_DATA_W-1:0]  s_tdata,  // [7:0] pixel_in
    input  wire logic                          s_tuser,  // [0] req_type
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // [15:0] pixel_out, [25:16] out_col, [37:26] out_row, [39:38] zero
    output logic [icb_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast   // frame_last
);

    logic                       q_push;
    icb_pkg::job_t              q_job;
    icb_pkg::wr_t               wr;
    icb_pkg::cfg_t              cfg;
    logic [icb_pkg::QLVL_W-1:0] q_level;
    logic                       q_pop;
    logic                       q_valid;
    icb_pkg::job_t              q_head;

    icb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .q_level   (q_level),
        .q_push    (q_push),
        .q_job     (q_job),
        .wr        (wr),
        .cfg       (cfg)
    );

    icb_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_job   (q_job),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_job   (q_head),
        .level      (q_level)
    );

    icb_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr       (wr),
        .cfg      (cfg),
        .q_valid  (q_valid),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

>>> rtl/icb_ram.sv
// ----------------------------------------------------------------------------
// icb_ram: generic simple dual-port RAM
// One write port and one registered read port; a read at the address being
// written returns the old contents.
// ----------------------------------------------------------------------------
`default_nettype none

module icb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icb_front.sv
// ----------------------------------------------------------------------------
// icb_front: request intake and output scheduling
// Holds the configuration, stores incoming pixels, tracks input and output
// positions and issues one output request whenever all its taps are present.
// ----------------------------------------------------------------------------
`default_nettype none

module icb_front (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wr_en,
    input  wire logic [icb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [icb_pkg::CFG_W-1:0]       cfg_data,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [icb_pkg::S_DATA_W-1:0]    s_tdata,
    input  wire logic                            s_tuser,
    input  wire logic [icb_pkg::QLVL_W-1:0]      q_level,
    output logic                                 q_push,
    output icb_pkg::job_t                        q_job,
    output icb_pkg::wr_t                         wr,
    output icb_pkg::cfg_t                        cfg
);

    localparam int COL_W = icb_pkg::COL_W;
    localparam int ROW_W = icb_pkg::ROW_W;
    localparam int WID_W = icb_pkg::WID_W;

    logic [icb_pkg::NWORD-1:0][icb_pkg::CFG_W-1:0] coef_reg;
    logic [WID_W-1:0] width_reg;
    logic [ROW_W-1:0] height_reg;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] em_col_reg, em_col_next;
    logic [ROW_W-1:0] em_row_reg, em_row_next;
    logic             done_reg, done_next;

    logic [WID_W-1:0] weff;
    logic [ROW_W-1:0] heff;
    logic             accept;
    logic             is_pix;
    logic             done_mid;
    logic [ROW_W:0]   nr;
    logic [COL_W:0]   nc;
    logic             ready;
    logic             emit;
    logic             last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_reg   <= '0;
            width_reg  <= WID_W'(1024);
            height_reg <= ROW_W'(1024);
        end else if (cfg_wr_en) begin
            case (icb_pkg::reg_idx_t'(cfg_index))
                icb_pkg::REG_COEF0:  coef_reg[0] <= cfg_data;
                icb_pkg::REG_COEF1:  coef_reg[1] <= cfg_data;
                icb_pkg::REG_COEF2:  coef_reg[2] <= cfg_data;
                icb_pkg::REG_COEF3:  coef_reg[3] <= cfg_data;
                icb_pkg::REG_COEF4:  coef_reg[4] <= cfg_data;
                icb_pkg::REG_WIDTH:  width_reg   <= cfg_data[WID_W-1:0];
                icb_pkg::REG_HEIGHT: height_reg  <= cfg_data[ROW_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (width_reg == '0) begin
            weff = WID_W'(1);
        end else if (width_reg > WID_W'(icb_pkg::MAX_WIDTH)) begin
            weff = WID_W'(icb_pkg::MAX_WIDTH);
        end else begin
            weff = width_reg;
        end
        heff = (height_reg == '0) ? ROW_W'(1) : height_reg;
    end

    assign s_tready = (q_level < icb_pkg::QLVL_W'(icb_pkg::QDEPTH)) &&
                      ((weff >= WID_W'(icb_pkg::SAFE_W)) || (q_level == '0));
    assign accept = s_tvalid && s_tready;
    // A pixel that arrives while the previous frame is still draining is dropped.
    assign is_pix = (icb_pkg::req_t'(s_tuser) == icb_pkg::REQ_PIXEL) && !done_reg;

    always_comb begin
        in_col_next = in_col_reg;
        in_row_next = in_row_reg;
        done_mid    = done_reg;
        if (accept && is_pix) begin
            if (({1'b0, in_col_reg} + (COL_W+1)'(1)) >= weff) begin
                in_col_next = '0;
                if (({1'b0, in_row_reg} + (ROW_W+1)'(1)) >= {1'b0, heff}) begin
                    in_row_next = '0;
                    done_mid    = 1'b1;
                end else begin
                    in_row_next = in_row_reg + ROW_W'(1);
                end
            end else begin
                in_col_next = in_col_reg + COL_W'(1);
            end
        end

        nr = {1'b0, em_row_reg} + (ROW_W+1)'(icb_pkg::KHI);
        if (nr > {1'b0, heff - ROW_W'(1)}) begin
            nr = {1'b0, heff - ROW_W'(1)};
        end
        nc = {1'b0, em_col_reg} + (COL_W+1)'(icb_pkg::KHI);
        if (nc > (weff - WID_W'(1))) begin
            nc = weff - WID_W'(1);
        end
        ready = done_mid || (nr < {1'b0, in_row_next}) ||
                ((nr == {1'b0, in_row_next}) && (nc < {1'b0, in_col_next}));
        emit  = accept && ready;

        em_col_next = em_col_reg;
        em_row_next = em_row_reg;
        last        = 1'b0;
        done_next   = done_mid;
        if (emit) begin
            if (({1'b0, em_col_reg} + (COL_W+1)'(1)) >= weff) begin
                em_col_next = '0;
                if (({1'b0, em_row_reg} + (ROW_W+1)'(1)) >= {1'b0, heff}) begin
                    em_row_next = '0;
                    last        = 1'b1;
                    done_next   = 1'b0;
                end else begin
                    em_row_next = em_row_reg + ROW_W'(1);
                end
            end else begin
                em_col_next = em_col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_col_reg <= '0;
            in_row_reg <= '0;
            em_col_reg <= '0;
            em_row_reg <= '0;
            done_reg   <= 1'b0;
        end else begin
            in_col_reg <= in_col_next;
            in_row_reg <= in_row_next;
            em_col_reg <= em_col_next;
            em_row_reg <= em_row_next;
            done_reg   <= done_next;
        end
    end

    always_comb begin
        wr.en   = accept && is_pix;
        wr.slot = icb_pkg::slot_of(in_row_reg);
        if ({1'b0, in_col_reg} > (COL_W+1)'(icb_pkg::MAX_WIDTH - 1)) begin
            wr.addr = icb_pkg::ADDR_W'(icb_pkg::MAX_WIDTH - 1);
        end else begin
            wr.addr = icb_pkg::ADDR_W'(in_col_reg);
        end
        wr.data = s_tdata[icb_pkg::PIX_W-1:0];
    end

    assign q_push     = emit;
    assign q_job.row  = em_row_reg;
    assign q_job.col  = em_col_reg;
    assign q_job.last = last;

    assign cfg.coef   = coef_reg;
    assign cfg.width  = weff;
    assign cfg.height = heff;

endmodule

`default_nettype wire

>>> rtl/icb_queue.sv
// ----------------------------------------------------------------------------
// icb_queue: short request queue between front and back end
// Holds output requests so that intake keeps going while the back end stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module icb_queue (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       push,
    input  wire icb_pkg::job_t              push_job,
    input  wire logic                       pop,
    output logic                            head_valid,
    output icb_pkg::job_t                   head_job,
    output logic [icb_pkg::QLVL_W-1:0]      level
);

    icb_pkg::job_t mem_reg [icb_pkg::QDEPTH];
    logic [icb_pkg::QPTR_W-1:0] wptr_reg, rptr_reg;
    logic [icb_pkg::QLVL_W-1:0] count_reg, count_next;
    logic do_pop;

    assign do_pop     = pop && (count_reg != '0);
    assign head_valid = (count_reg != '0);
    assign head_job   = mem_reg[rptr_reg];
    assign level      = count_reg;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + icb_pkg::QLVL_W'(1);
        end else if (!push && do_pop) begin
            count_next = count_reg - icb_pkg::QLVL_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wptr_reg <= wptr_reg + icb_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                rptr_reg <= rptr_reg + icb_pkg::QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/icb_back.sv
// ----------------------------------------------------------------------------
// icb_back: tap fetch and multiply-accumulate pipeline
// Clamps tap positions, reads all taps from the line memories in the same cycle
// and runs one saturating tap per pipeline stage, column by column.
// ----------------------------------------------------------------------------
`default_nettype none

module icb_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire icb_pkg::wr_t                  wr,
    input  wire icb_pkg::cfg_t                 cfg,
    input  wire logic                          q_valid,
    input  wire icb_pkg::job_t                 q_head,
    output logic                               q_pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [icb_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tlast
);

    localparam int K      = icb_pkg::KSIZE;
    localparam int NTAP   = icb_pkg::NTAP;
    localparam int PIX_W  = icb_pkg::PIX_W;
    localparam int ROW_W  = icb_pkg::ROW_W;
    localparam int COL_W  = icb_pkg::COL_W;
    localparam int ADDR_W = icb_pkg::ADDR_W;
    localparam int SLOT_W = icb_pkg::SLOT_W;
    localparam int SUM_W  = icb_pkg::SUM_W;
    localparam int T_W    = icb_pkg::T_W;

    logic en;
    logic [ADDR_W-1:0] caddr [K];
    logic [SLOT_W-1:0] rslot [K];
    logic [PIX_W-1:0]  ram_q [K][K];

    logic              v1_reg;
    icb_pkg::job_t     meta1_reg;
    logic [SLOT_W-1:0] slot1_reg [K];
    logic [NTAP-1:0][PIX_W-1:0] pix0;

    logic                       stg_valid_reg [NTAP];
    icb_pkg::job_t              stg_meta_reg  [NTAP];
    logic [SUM_W-1:0]           stg_sum_reg   [NTAP];
    logic [NTAP-1:0][PIX_W-1:0] stg_pix_reg   [NTAP];

    // The whole pipeline advances together; the last stage is the output register.
    assign en    = !m_tvalid || m_tready;
    assign q_pop = en && q_valid;

    always_comb begin
        logic signed [ROW_W+1:0] rv;
        logic signed [COL_W+1:0] cv;
        logic [ROW_W-1:0] rr;
        logic [ROW_W-1:0] hmax;
        logic [icb_pkg::WID_W-1:0] wmax;
        hmax = cfg.height - ROW_W'(1);
        wmax = cfg.width - icb_pkg::WID_W'(1);
        for (int ky = 0; ky < K; ky++) begin
            rv = $signed({2'b00, q_head.row}) + $signed((ROW_W+2)'(ky - icb_pkg::KLO));
            if (rv < 0) begin
                rr = '0;
            end else if (rv > $signed({2'b00, hmax})) begin
                rr = hmax;
            end else begin
                rr = ROW_W'(rv);
            end
            rslot[ky] = icb_pkg::slot_of(rr);
        end
        for (int kx = 0; kx < K; kx++) begin
            cv = $signed({2'b00, q_head.col}) + $signed((COL_W+2)'(kx - icb_pkg::KLO));
            if (cv < 0) begin
                caddr[kx] = '0;
            end else if (cv > $signed({1'b0, wmax})) begin
                caddr[kx] = ADDR_W'(wmax);
            end else begin
                caddr[kx] = ADDR_W'(cv);
            end
        end
    end

    // One copy of each line slot per kernel column, so every tap has a read port.
    for (genvar s = 0; s < K; s++) begin : g_slot
        for (genvar kx = 0; kx < K; kx++) begin : g_copy
            icb_ram #(
                .WIDTH(PIX_W),
                .DEPTH(icb_pkg::MAX_WIDTH)
            ) u_ram (
                .aclk  (aclk),
                .we    (wr.en && (wr.slot == SLOT_W'(s))),
                .waddr (wr.addr),
                .wdata (wr.data),
                .re    (en),
                .raddr (caddr[kx]),
                .rdata (ram_q[s][kx])
            );
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= q_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            meta1_reg <= q_head;
            for (int ky = 0; ky < K; ky++) begin
                slot1_reg[ky] <= rslot[ky];
            end
        end
    end

    always_comb begin
        for (int kx = 0; kx < K; kx++) begin
            for (int ky = 0; ky < K; ky++) begin
                pix0[kx*K + ky] = ram_q[slot1_reg[ky]][kx];
            end
        end
    end

    for (genvar c = 0; c < NTAP; c++) begin : g_tap
        localparam int KX   = c / K;
        localparam int KY   = c % K;
        localparam int KIDX = KY * K + KX;
        localparam int WIDX = KIDX / icb_pkg::COEFS_PER_WORD;
        localparam int BIT0 = icb_pkg::COEF_W * (KIDX % icb_pkg::COEFS_PER_WORD);

        logic                       in_valid;
        icb_pkg::job_t              in_meta;
        logic [SUM_W-1:0]           in_sum;
        logic [NTAP-1:0][PIX_W-1:0] in_pix;
        logic signed [icb_pkg::COEF_W-1:0] cf;
        logic signed [icb_pkg::PROD_W-1:0] prod;
        logic signed [T_W-1:0]             t;
        logic [SUM_W-1:0]                  sum_next;

        if (c == 0) begin : g_first
            assign in_valid = v1_reg;
            assign in_meta  = meta1_reg;
            assign in_sum   = '0;
            assign in_pix   = pix0;
        end else begin : g_rest
            assign in_valid = stg_valid_reg[c-1];
            assign in_meta  = stg_meta_reg[c-1];
            assign in_sum   = stg_sum_reg[c-1];
            assign in_pix   = stg_pix_reg[c-1];
        end

        always_comb begin
            cf   = $signed(cfg.coef[WIDX][BIT0 +: icb_pkg::COEF_W]);
            prod = $signed({1'b0, in_pix[c]}) * cf;
            t    = $signed({2'b00, in_sum, 8'b0}) + T_W'(prod);
            // Negative partial sums clear; large ones saturate at full scale.
            if (t[T_W-1]) begin
                sum_next = '0;
            end else if (t[T_W-2]) begin
                sum_next = '1;
            end else begin
                sum_next = t[SUM_W+7:8];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                stg_valid_reg[c] <= 1'b0;
            end else if (en) begin
                stg_valid_reg[c] <= in_valid;
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                stg_meta_reg[c] <= in_meta;
                stg_sum_reg[c]  <= sum_next;
                stg_pix_reg[c]  <= in_pix;
            end
        end
    end

    assign m_tvalid = stg_valid_reg[NTAP-1];
    assign m_tlast  = stg_meta_reg[NTAP-1].last;
    assign m_tdata  = {2'b00, stg_meta_reg[NTAP-1].row, stg_meta_reg[NTAP-1].col,
                       stg_sum_reg[NTAP-1]};

endmodule

`default_nettype wire

>>> rtl/icb_checker.sv
// ----------------------------------------------------------------------------
// icb_checker: port-level checks of the convolution block
// Watches the output stream for reset behavior, hold under stall and the
// raster order of result positions.
// ----------------------------------------------------------------------------
`default_nettype none

module icb_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [icb_pkg::M_DATA_W-1:0]  m_tdata,
    input wire logic                          m_tlast
);

    logic out_acc;
    assign out_acc = m_tvalid && m_tready;

    a_reset_idle: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // Back-to-back results inside a frame step one column or wrap to column zero.
    a_col_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && !m_tlast) ##1 out_acc |->
            (m_tdata[25:16] == 10'($past(m_tdata[25:16]) + 10'd1)) ||
            (m_tdata[25:16] == 10'd0))
        else $error("result column out of raster order");

    a_frame_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_tlast) ##1 out_acc |->
            (m_tdata[25:16] == 10'd0) && (m_tdata[37:26] == 12'd0))
        else $error("result after end of frame not at origin");

endmodule

bind image_convolution_clamped_border_top icb_checker u_icb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire
